@@ src/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types and codes of the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_NO_QUOTE  = 4'd1;
    localparam logic [3:0] ERR_CONTROL   = 4'd2;
    localparam logic [3:0] ERR_ESC_END   = 4'd3;
    localparam logic [3:0] ERR_BAD_ESC   = 4'd4;
    localparam logic [3:0] ERR_SHORT_U   = 4'd5;
    localparam logic [3:0] ERR_BAD_HEX   = 4'd6;
    localparam logic [3:0] ERR_SURROGATE = 4'd7;
    localparam logic [3:0] ERR_UNTERM    = 4'd8;

    // decoder state carried between words
    typedef struct packed {
        phase_t      phase;
        logic [1:0]  hex_count;
        logic [15:0] accum;
    } dec_state_t;

    // all results of one input word: one to three entries
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        kind_t           kind;
        logic [3:0]      err;
    } burst_t;

endpackage

@@ src/jsu_decode.sv @@
// ----------------------------------------------------------------------------
// jsu_decode
// per-word decode: next state and the burst of results of one input word
// ----------------------------------------------------------------------------
module jsu_decode (
    input  jsu_pkg::dec_state_t state,
    input  logic [7:0]          in_byte,
    input  logic                input_end,
    output jsu_pkg::dec_state_t state_next,
    output jsu_pkg::burst_t     burst,
    output logic                has_result
);
    import jsu_pkg::*;

    // hex digit value, bit 4 set when the byte is no hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b0, b[3:0]};
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            r = {1'b0, b[3:0] + 4'd9};
        return r;
    endfunction

    logic [4:0]  hv;
    logic [15:0] cp;

    assign hv = hex_val(in_byte);
    assign cp = {state.accum[11:0], hv[3:0]};

    always_comb
    begin
        state_next  = state;
        burst.bytes = '0;
        burst.cnt   = 2'd1;
        burst.kind  = KIND_ERR;
        burst.err   = ERR_NONE;
        has_result  = 1'b0;

        unique case (state.phase)
            PH_WAIT:
            begin
                if (input_end || in_byte != 8'h22)
                begin
                    has_result = 1'b1;
                    burst.err  = ERR_NO_QUOTE;
                end
                else
                    state_next.phase = PH_STR;
            end
            PH_STR:
            begin
                if (input_end)
                begin
                    has_result = 1'b1;
                    burst.err  = ERR_UNTERM;
                end
                else if (in_byte == 8'h22)
                begin
                    has_result = 1'b1;
                    burst.kind = KIND_DONE;
                end
                else if (in_byte < 8'h20)
                begin
                    has_result = 1'b1;
                    burst.err  = ERR_CONTROL;
                end
                else if (in_byte == 8'h5c)
                    state_next.phase = PH_ESC;
                else
                begin
                    has_result     = 1'b1;
                    burst.kind     = KIND_BYTE;
                    burst.bytes[0] = in_byte;
                end
            end
            PH_ESC:
            begin
                has_result = 1'b1;
                burst.kind = KIND_BYTE;
                state_next.phase = PH_STR;
                if (input_end)
                begin
                    burst.kind = KIND_ERR;
                    burst.err  = ERR_ESC_END;
                end
                else
                begin
                    case (in_byte)
                        8'h22, 8'h5c, 8'h2f: burst.bytes[0] = in_byte;
                        8'h62:               burst.bytes[0] = 8'h08;
                        8'h66:               burst.bytes[0] = 8'h0c;
                        8'h6e:               burst.bytes[0] = 8'h0a;
                        8'h72:               burst.bytes[0] = 8'h0d;
                        8'h74:               burst.bytes[0] = 8'h09;
                        8'h75:
                        begin
                            has_result           = 1'b0;
                            state_next.phase     = PH_HEX;
                            state_next.hex_count = 2'd0;
                            state_next.accum     = '0;
                        end
                        default:
                        begin
                            burst.kind = KIND_ERR;
                            burst.err  = ERR_BAD_ESC;
                        end
                    endcase
                end
            end
            PH_HEX:
            begin
                if (input_end)
                begin
                    has_result = 1'b1;
                    burst.err  = ERR_SHORT_U;
                end
                else if (hv[4])
                begin
                    has_result = 1'b1;
                    burst.err  = ERR_BAD_HEX;
                end
                else if (state.hex_count != 2'd3)
                begin
                    state_next.accum     = cp;
                    state_next.hex_count = state.hex_count + 2'd1;
                end
                else if (cp[15:11] == 5'b11011)
                begin
                    has_result = 1'b1;
                    burst.err  = ERR_SURROGATE;
                end
                else
                begin
                    has_result           = 1'b1;
                    burst.kind           = KIND_BYTE;
                    state_next.phase     = PH_STR;
                    state_next.hex_count = 2'd0;
                    state_next.accum     = '0;
                    if (cp <= 16'h007f)
                        burst.bytes[0] = cp[7:0];
                    else if (cp <= 16'h07ff)
                    begin
                        burst.cnt      = 2'd2;
                        burst.bytes[0] = {3'b110, cp[10:6]};
                        burst.bytes[1] = {2'b10, cp[5:0]};
                    end
                    else
                    begin
                        burst.cnt      = 2'd3;
                        burst.bytes[0] = {4'b1110, cp[15:12]};
                        burst.bytes[1] = {2'b10, cp[11:6]};
                        burst.bytes[2] = {2'b10, cp[5:0]};
                    end
                end
            end
            default:
            begin
                state_next.phase = PH_WAIT;
            end
        endcase

        // every error and every completion drops back to waiting
        if (has_result && burst.kind != KIND_BYTE)
        begin
            state_next.phase     = PH_WAIT;
            state_next.hex_count = 2'd0;
            state_next.accum     = '0;
        end
    end

endmodule

@@ src/json_string_unescape.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape
// streaming decoder for one json string literal into utf-8 bytes
// ----------------------------------------------------------------------------
// usage
//   input stream s_axis: one text byte per word in tdata, tuser set marks
//   the end of the text (the byte is then ignored). the first byte must be
//   the opening quote.
//   output stream m_axis: decoded bytes (tuser 0), a completion word at the
//   closing quote (tuser 1) or an error word (tuser 2, code in tdata[11:8]).
//   tlast marks the final result word caused by one input word.
// timing
//   one input word per cycle while the receiver does not stall. the decode
//   is done on the accepted word in the same cycle and the burst of one to
//   three results lands in a staging register at the accepting edge; it
//   moves on to the output register once that register is free, and the
//   first result is offered from there. the output register sends one word
//   per cycle, so only a \u escape that expands to two or three utf-8 bytes
//   holds the input back.
// reset and stall
//   reset returns the decoder to waiting for an opening quote and empties
//   both registers. while the receiver stalls, the output holds; input words
//   that give no result are still taken, and one word with results is taken
//   into the staging register before the input stalls.
// ----------------------------------------------------------------------------
module json_string_unescape (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] input_end
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] error_code, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // [0] last
);
    import jsu_pkg::*;

    dec_state_t state_reg, state_next;
    burst_t     dec_burst;
    logic       dec_has;

    // staging register and output register, each one burst
    burst_t     stg_reg;
    logic       stg_valid_reg;
    burst_t     out_reg;
    logic       out_valid_reg;
    logic [1:0] idx_reg;

    logic s_fire, m_fire, out_done, out_free, stg_move, last_word;

    jsu_decode u_decode (
        .state      (state_reg),
        .in_byte    (s_axis_tdata),
        .input_end  (s_axis_tuser),
        .state_next (state_next),
        .burst      (dec_burst),
        .has_result (dec_has)
    );

    // handshake bookkeeping
    assign last_word     = (idx_reg == out_reg.cnt - 2'd1);
    assign m_fire        = m_axis_tvalid && m_axis_tready;
    assign out_done      = m_fire && last_word;
    assign out_free      = !out_valid_reg || out_done;
    assign stg_move      = stg_valid_reg && out_free;
    assign s_axis_tready = !stg_valid_reg || stg_move;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // decoder state advances on every accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase     <= PH_WAIT;
            state_reg.hex_count <= 2'd0;
            state_reg.accum     <= '0;
        end
        else if (s_fire)
            state_reg <= state_next;
    end

    // control of the two burst registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            stg_valid_reg <= (stg_valid_reg && !stg_move) || (s_fire && dec_has);
            if (stg_move)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else if (out_done)
                out_valid_reg <= 1'b0;
            else if (m_fire)
                idx_reg <= idx_reg + 2'd1;
        end
    end

    // burst payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_fire && dec_has)
            stg_reg <= dec_burst;
        if (stg_move)
            out_reg <= stg_reg;
    end

    // present the current entry of the output burst
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_reg.err, out_reg.bytes[idx_reg]};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = last_word;

endmodule

@@ src/jsu_checker.sv @@
// ----------------------------------------------------------------------------
// jsu_checker
// port-level checks on the output stream of the unescaper
// ----------------------------------------------------------------------------
module jsu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import jsu_pkg::*;

    // no word before any input was ever taken after reset
    logic seen_in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_in_reg <= 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            seen_in_reg <= 1'b1;
    end

    // completion and error words are always the only result of their word
    a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_BYTE |-> m_axis_tlast)
        else $error("status word without tlast");

    // error code only on error words, byte only on byte words
    a_err_field: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_ERR |-> m_axis_tdata[11:8] == ERR_NONE)
        else $error("error code on non-error word");

    a_byte_field: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_BYTE |-> m_axis_tdata[7:0] == 8'd0)
        else $error("byte on status word");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> seen_in_reg)
        else $error("output word with no input taken");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output word changed");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
